@@ rtl/assert_macros.svh @@
// Assertion macros used by the top RTL file of the cube map texel unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
// Check that an antecedent implies a consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/cmtx_pkg.sv @@
// Shared types, constants and helpers of the cube map texel unit.
`timescale 1ns / 1ps
`default_nettype none
package cmtx_pkg;
	localparam int COMP_W        = 16;
	localparam int SIZE_W        = 13;
	localparam int MAX_FACE_SIZE = 4096;
	localparam int COORD_W       = 12;
	localparam int FACE_W        = 3;
	localparam int IDX_W         = 27;
	localparam int MAG_W         = COMP_W;
	localparam int DEN_W         = COMP_W + 1;
	localparam int NUM_W         = DEN_W + COORD_W;
	localparam int DIV_STAGES    = COORD_W;
	localparam int FROW_W        = 15;

	localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
	localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
	localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
	localparam logic [FACE_W-1:0] FACE_LAST  = 3'd5;

	typedef struct packed {
		logic signed [COMP_W-1:0] vec_x;
		logic signed [COMP_W-1:0] vec_y;
		logic signed [COMP_W-1:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic [FACE_W-1:0]  face;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [IDX_W-1:0]   texel_index;
		logic               zero_vector;
	} texel_t;

	typedef struct packed {
		logic [FACE_W-1:0] face;
		logic              zero;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] num_col;
		logic [NUM_W-1:0] num_row;
		logic [DEN_W-1:0] den;
		side_t            side;
	} div_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		side_t              side;
	} div_out_t;

	// Clamp the face size register to the legal range.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] fs);
		logic [SIZE_W-1:0] r;
		if (fs == '0)
			r = SIZE_W'(1);
		else if (fs > SIZE_W'(MAX_FACE_SIZE))
			r = SIZE_W'(MAX_FACE_SIZE);
		else
			r = fs;
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/cmtx_front.sv @@
// Face selection and numerator scaling stages of the cube map texel unit.
`timescale 1ns / 1ps
`default_nettype none
module cmtx_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         up_valid,
	input  wire cmtx_pkg::vec_t               up_word,
	output logic                              take,
	input  wire logic [cmtx_pkg::COORD_W-1:0] span,
	output logic                              dn_valid,
	output cmtx_pkg::div_in_t                 dn_word,
	input  wire logic                         dn_take
);
	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	cmtx_pkg::vec_t                     vec_s1;
	logic [cmtx_pkg::MAG_W-1:0]         ax_s1, ay_s1, az_s1;
	logic [cmtx_pkg::FACE_W-1:0]        face_s2;
	logic [cmtx_pkg::MAG_W-1:0]         d_s2;
	logic signed [cmtx_pkg::DEN_W-1:0]  nt_s2, nu_s2;
	logic                               zero_s2;
	cmtx_pkg::div_in_t                  word_s3;

	logic signed [cmtx_pkg::DEN_W-1:0]  x17, y17, z17;
	logic [2:0]                         code;
	logic [cmtx_pkg::FACE_W-1:0]        face_c;
	logic [cmtx_pkg::MAG_W-1:0]         d_c;
	logic signed [cmtx_pkg::DEN_W-1:0]  nt_c, nu_c, dd;
	logic signed [cmtx_pkg::DEN_W:0]    at_c, au_c;

	assign adv_s3 = !v_s3 || dn_take;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign take   = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= up_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	// Magnitudes: the most negative value maps to 2^(w-1), which fits unsigned.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			vec_s1 <= up_word;
			ax_s1  <= up_word.vec_x[cmtx_pkg::COMP_W-1] ? cmtx_pkg::MAG_W'(-up_word.vec_x)
			                                           : cmtx_pkg::MAG_W'(up_word.vec_x);
			ay_s1  <= up_word.vec_y[cmtx_pkg::COMP_W-1] ? cmtx_pkg::MAG_W'(-up_word.vec_y)
			                                           : cmtx_pkg::MAG_W'(up_word.vec_y);
			az_s1  <= up_word.vec_z[cmtx_pkg::COMP_W-1] ? cmtx_pkg::MAG_W'(-up_word.vec_z)
			                                           : cmtx_pkg::MAG_W'(up_word.vec_z);
		end
	end

	always_comb begin
		x17  = cmtx_pkg::DEN_W'(vec_s1.vec_x);
		y17  = cmtx_pkg::DEN_W'(vec_s1.vec_y);
		z17  = cmtx_pkg::DEN_W'(vec_s1.vec_z);
		code = {az_s1 > ax_s1, ay_s1 > az_s1, ax_s1 > ay_s1};
		unique case (code)
			3'd1, 3'd3: begin
				face_c = cmtx_pkg::FACE_POS_X | cmtx_pkg::FACE_W'(x17 < 0);
				d_c    = ax_s1;
				nt_c   = (x17 < 0) ? z17 : -z17;
				nu_c   = -y17;
			end
			3'd2, 3'd6: begin
				face_c = cmtx_pkg::FACE_POS_Y | cmtx_pkg::FACE_W'(y17 < 0);
				d_c    = ay_s1;
				nt_c   = x17;
				nu_c   = (y17 < 0) ? -z17 : z17;
			end
			default: begin
				face_c = cmtx_pkg::FACE_POS_Z | cmtx_pkg::FACE_W'(z17 < 0);
				d_c    = az_s1;
				nt_c   = (z17 < 0) ? -x17 : x17;
				nu_c   = -y17;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			face_s2 <= face_c;
			d_s2    <= d_c;
			nt_s2   <= nt_c;
			nu_s2   <= nu_c;
			zero_s2 <= (vec_s1.vec_x == '0) && (vec_s1.vec_y == '0) && (vec_s1.vec_z == '0);
		end
	end

	// Shift the ratios into [0, 2d], then scale by the span.
	always_comb begin
		dd   = $signed({1'b0, d_s2});
		at_c = (cmtx_pkg::DEN_W+1)'(nt_s2) + (cmtx_pkg::DEN_W+1)'(dd);
		au_c = (cmtx_pkg::DEN_W+1)'(nu_s2) + (cmtx_pkg::DEN_W+1)'(dd);
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			word_s3.num_col   <= cmtx_pkg::NUM_W'(at_c[cmtx_pkg::DEN_W-1:0] * span);
			word_s3.num_row   <= cmtx_pkg::NUM_W'(au_c[cmtx_pkg::DEN_W-1:0] * span);
			word_s3.den       <= {d_s2, 1'b0};
			word_s3.side.face <= face_s2;
			word_s3.side.zero <= zero_s2;
		end
	end

	assign dn_valid = v_s3;
	assign dn_word  = word_s3;
endmodule
`default_nettype wire

@@ rtl/cmtx_div.sv @@
// Pipelined restoring divider for the column and row quotients.
`timescale 1ns / 1ps
`default_nettype none
module cmtx_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              up_valid,
	input  wire cmtx_pkg::div_in_t up_word,
	output logic                   take,
	output logic                   dn_valid,
	output cmtx_pkg::div_out_t     dn_word,
	input  wire logic              dn_take
);
	localparam int N = cmtx_pkg::DIV_STAGES;

	logic                           v_s   [N];
	logic [cmtx_pkg::NUM_W-1:0]     rc_s  [N];
	logic [cmtx_pkg::NUM_W-1:0]     rr_s  [N];
	logic [cmtx_pkg::DEN_W-1:0]     den_s [N];
	logic [cmtx_pkg::COORD_W-1:0]   qc_s  [N];
	logic [cmtx_pkg::COORD_W-1:0]   qr_s  [N];
	cmtx_pkg::side_t                sd_s  [N];
	logic                           adv   [N+1];

	assign adv[N] = dn_take;
	assign take   = adv[0];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic                         pv;
		logic [cmtx_pkg::NUM_W-1:0]   prc, prr, trial;
		logic [cmtx_pkg::DEN_W-1:0]   pden;
		logic [cmtx_pkg::COORD_W-1:0] pqc, pqr;
		cmtx_pkg::side_t              psd;
		logic                         bc, br;

		if (k == 0) begin : g_first
			assign pv   = up_valid;
			assign prc  = up_word.num_col;
			assign prr  = up_word.num_row;
			assign pden = up_word.den;
			assign pqc  = '0;
			assign pqr  = '0;
			assign psd  = up_word.side;
		end else begin : g_next
			assign pv   = v_s[k-1];
			assign prc  = rc_s[k-1];
			assign prr  = rr_s[k-1];
			assign pden = den_s[k-1];
			assign pqc  = qc_s[k-1];
			assign pqr  = qr_s[k-1];
			assign psd  = sd_s[k-1];
		end

		// Quotient bit weight for this stage.
		assign trial = cmtx_pkg::NUM_W'(pden) << (N - 1 - k);
		assign bc    = prc >= trial;
		assign br    = prr >= trial;
		assign adv[k] = !v_s[k] || adv[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (adv[k])
				v_s[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rc_s[k]  <= bc ? prc - trial : prc;
				rr_s[k]  <= br ? prr - trial : prr;
				den_s[k] <= pden;
				qc_s[k]  <= {pqc[cmtx_pkg::COORD_W-2:0], bc};
				qr_s[k]  <= {pqr[cmtx_pkg::COORD_W-2:0], br};
				sd_s[k]  <= psd;
			end
		end
	end

	assign dn_valid       = v_s[N-1];
	assign dn_word.column = qc_s[N-1];
	assign dn_word.row    = qr_s[N-1];
	assign dn_word.side   = sd_s[N-1];
endmodule
`default_nettype wire

@@ rtl/cmtx_index.sv @@
// Linear texel index stages and output register of the cube map texel unit.
`timescale 1ns / 1ps
`default_nettype none
module cmtx_index (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        up_valid,
	input  wire cmtx_pkg::div_out_t          up_word,
	output logic                             take,
	input  wire logic [cmtx_pkg::SIZE_W-1:0] size,
	output logic                             dn_valid,
	output cmtx_pkg::texel_t                 dn_word,
	input  wire logic                        dn_take
);
	logic v_s1, v_s2, adv_s1, adv_s2;
	logic [cmtx_pkg::FROW_W-1:0]  fr_s1;
	cmtx_pkg::div_out_t           w_s1;
	cmtx_pkg::texel_t             out_s2;

	assign adv_s2 = !v_s2 || dn_take;
	assign adv_s1 = !v_s1 || adv_s2;
	assign take   = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= up_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			w_s1  <= up_word;
			fr_s1 <= cmtx_pkg::FROW_W'(up_word.side.face * size + up_word.row);
		end
	end

	// Drop face, coordinates and index to zero and set the zero flag for a zero vector.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			if (w_s1.side.zero) begin
				out_s2.face        <= '0;
				out_s2.column      <= '0;
				out_s2.row         <= '0;
				out_s2.texel_index <= '0;
				out_s2.zero_vector <= 1'b1;
			end else begin
				out_s2.face        <= w_s1.side.face;
				out_s2.column      <= w_s1.column;
				out_s2.row         <= w_s1.row;
				out_s2.texel_index <= cmtx_pkg::IDX_W'(fr_s1 * size + w_s1.column);
				out_s2.zero_vector <= 1'b0;
			end
		end
	end

	assign dn_valid = v_s2;
	assign dn_word  = out_s2;
endmodule
`default_nettype wire

@@ rtl/cube_map_direction_to_texel.sv @@
// A direction word passes the front stages, the divider and the index stages to its texel word.
// Throughput: one word per cycle while out_stall is low; every stage holds its word on stall.
// Depth is set by the 12-stage divider, one quotient bit per stage.
// Bubbles collapse, so input is stalled only when all 17 stages are full.
// Reset clears all valid bits and sets face_size to 512.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cube_map_direction_to_texel (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [cmtx_pkg::SIZE_W-1:0] cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire cmtx_pkg::vec_t              in_word,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output cmtx_pkg::texel_t                 out_word
);
	logic [cmtx_pkg::SIZE_W-1:0]  face_size_q;
	logic [cmtx_pkg::SIZE_W-1:0]  size;
	logic [cmtx_pkg::COORD_W-1:0] span;

	logic               front_take, div_take, idx_take;
	logic               front_valid, div_valid;
	cmtx_pkg::div_in_t  front_word;
	cmtx_pkg::div_out_t div_word;

	// Hold the face size; the user must change it only while the pipeline is empty (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			face_size_q <= cmtx_pkg::SIZE_W'(512);
		else if (cfg_we)
			face_size_q <= cfg_data;
	end

	// Clamp the size and form the span size-1 used by the scaling.
	assign size = cmtx_pkg::eff_size(face_size_q);
	assign span = cmtx_pkg::COORD_W'(size - cmtx_pkg::SIZE_W'(1));

	// Front: magnitudes, face pick, numerators times span.
	cmtx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_word  (in_word),
		.take     (front_take),
		.span     (span),
		.dn_valid (front_valid),
		.dn_word  (front_word),
		.dn_take  (div_take)
	);

	// Divider: floor(num / 2d) for column and row in parallel lanes.
	cmtx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (front_valid),
		.up_word  (front_word),
		.take     (div_take),
		.dn_valid (div_valid),
		.dn_word  (div_word),
		.dn_take  (idx_take)
	);

	// Index: (face*size + row)*size + column, then the output register.
	cmtx_index u_index (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (div_valid),
		.up_word  (div_word),
		.take     (idx_take),
		.size     (size),
		.dn_valid (out_valid),
		.dn_word  (out_word),
		.dn_take  (!out_stall)
	);

	assign in_stall = !front_take;

	`ASSERT_ALWAYS(a_stall_needs_back, !in_stall || (out_valid && out_stall))
	`ASSERT_ALWAYS(a_face_range, !out_valid || (out_word.face <= cmtx_pkg::FACE_LAST))
	`ASSERT_ALWAYS(a_zero_clean, !(out_valid && out_word.zero_vector) || (out_word.face == '0 && out_word.column == '0 && out_word.row == '0 && out_word.texel_index == '0))
	`ASSERT_ALWAYS(a_coord_span, !out_valid || (out_word.column <= span && out_word.row <= span))
endmodule
`default_nettype wire
